[hdl/grst_pkg.sv]
package grst_pkg;

  // fixed field widths
  localparam int IDX_W  = 6;
  localparam int CFG_W  = 7;
  localparam int DATA_W = 32;

  localparam logic [CFG_W-1:0] GRID_RESET = 7'd64;

  // item kinds
  localparam logic KIND_UPDATE = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic [IDX_W-1:0]         cell_row;
    logic [IDX_W-1:0]         cell_col;
    logic signed [DATA_W-1:0] new_value;
    logic [IDX_W-1:0]         first_row;
    logic [IDX_W-1:0]         second_row;
    logic [IDX_W-1:0]         first_col;
    logic [IDX_W-1:0]         second_col;
  } grst_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] range_sum;
    logic                     index_error;
  } grst_out_t;

  // tree walker control and status
  typedef struct packed {
    logic start;
    logic adv;
  } walk_ctl_t;

  typedef struct packed {
    logic hit;
    logic fin;
  } walk_sts_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_QROW,
    ST_QCOL,
    ST_UDESC,
    ST_URDA,
    ST_URDB,
    ST_UWR,
    ST_DONE
  } grst_state_t;

endpackage

[hdl/grid_range_sum_tree.sv]
// Two-dimensional range-sum tree over a square grid.
// Command channel: an item is taken when start is high and busy is low.
// Kind update writes one cell; kind query sums an inclusive rectangle,
// with reversed bounds swapped. Any index at or beyond the grid size gives
// index_error and leaves the store untouched.
// Each item yields one result, on result for exactly one cycle with done
// high; the receiver cannot stall, and busy drops the cycle after done.
// An update records both paths, then rebuilds each node on them with up
// to two reads and one write on the store, which has one read port and
// one write port. A query steps the row walk and runs a column walk on
// each row node it stops on; store reads overlap the walk. An index
// error skips the walk and the store and goes straight to done.
// grid_size is written on the cfg channel (always ready); the user must write it
// only while idle, the block does not enforce this. 0 acts as 1 and values above MAX_GRID act as MAX_GRID.
// After reset the node store is cleared one entry a cycle, all
// (4*MAX_GRID)^2 entries rounded up to a power of two, 65536 by default;
// busy stays high meanwhile, but cfg writes are taken.
module grid_range_sum_tree import grst_pkg::*; #(
  parameter int MAX_GRID  = 64,
  parameter int SUM_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  grst_in_t         cmd,
  output logic             done,
  output grst_out_t        result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CFG_W-1:0] cfg_data
);

  localparam int RW = $clog2(MAX_GRID > 1 ? MAX_GRID : 2);
  localparam int NW = $clog2(MAX_GRID + 1);
  localparam int GW = (NW > CFG_W) ? NW : CFG_W;

  logic [CFG_W-1:0] grid_size;
  logic [NW-1:0]    n;
  logic [RW-1:0]    top;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) grid_size <= GRID_RESET;
    else if (cfg_valid && cfg_ready) grid_size <= cfg_data;
  end

  // effective side, clamped to 1..MAX_GRID
  always_comb begin
    if (grid_size == '0) n = NW'(1);
    else if (GW'(grid_size) > GW'(MAX_GRID)) n = NW'(MAX_GRID);
    else n = NW'(grid_size);
    top = RW'(n - 1'b1);
  end

  grst_ctrl #(.MAX_GRID(MAX_GRID), .SUM_WIDTH(SUM_WIDTH)) u_ctrl (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd), .n(n), .top(top),
    .busy(busy), .done(done), .result(result)
  );

endmodule

[hdl/grst_walk.sv]
// Walks one dimension of the segment tree and stops on each node that lies
// fully inside [qlo, qhi], left to right. A small stack keeps the ranges
// of the ancestors so the walk can climb back up.
module grst_walk import grst_pkg::*; #(
  parameter int MAX_GRID = 64,
  localparam int RW   = $clog2(MAX_GRID > 1 ? MAX_GRID : 2),
  localparam int VW   = $clog2(4 * MAX_GRID),
  localparam int SDEP = RW + 1,
  localparam int DW   = $clog2(SDEP)
) (
  input  logic          clk,
  input  logic          rst,
  input  walk_ctl_t     ctl,
  input  logic [RW-1:0] top,
  input  logic [RW-1:0] qlo,
  input  logic [RW-1:0] qhi,
  output walk_sts_t     sts,
  output logic [VW-1:0] node
);

  logic          run, run_next;
  logic          back, back_next;
  logic [VW-1:0] v, v_next;
  logic [DW-1:0] d, d_next, dm1;
  logic [RW-1:0] lo, lo_next, hi, hi_next, mid;
  logic [RW-1:0] qlo_r, qhi_r;
  logic          full, disj, push, mv;
  logic [RW-1:0] lo_stk [SDEP];
  logic [RW-1:0] hi_stk [SDEP];

  // classify the current node
  always_comb begin
    full = (qlo_r <= lo) && (hi <= qhi_r);
    disj = (hi < qlo_r) || (lo > qhi_r);
    mid  = RW'(({1'b0, lo} + {1'b0, hi}) >> 1);
    dm1  = (d == '0) ? '0 : DW'(d - 1'b1);
    mv   = back || (full && ctl.adv) || disj;
  end

  // next position
  always_comb begin
    run_next  = run;
    back_next = back;
    v_next    = v;
    d_next    = d;
    lo_next   = lo;
    hi_next   = hi;
    push      = 1'b0;
    if (ctl.start) begin
      run_next  = 1'b1;
      back_next = 1'b0;
      v_next    = VW'(1);
      d_next    = '0;
      lo_next   = '0;
      hi_next   = top;
    end else if (run) begin
      if (mv) begin
        if (v == VW'(1)) begin
          run_next = 1'b0;
        end else if (!v[0]) begin
          // on to the right sibling
          v_next    = VW'(v + 1'b1);
          lo_next   = RW'(hi + 1'b1);
          hi_next   = hi_stk[dm1];
          back_next = 1'b0;
        end else begin
          // climb to the parent, which is then finished
          v_next    = v >> 1;
          d_next    = dm1;
          lo_next   = lo_stk[dm1];
          hi_next   = hi_stk[dm1];
          back_next = 1'b1;
        end
      end else if (!full) begin
        // partial overlap: into the left child
        push    = 1'b1;
        v_next  = VW'(v << 1);
        d_next  = DW'(d + 1'b1);
        hi_next = mid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      back <= 1'b0;
    end else begin
      run  <= run_next;
      back <= back_next;
    end
    v  <= v_next;
    d  <= d_next;
    lo <= lo_next;
    hi <= hi_next;
    if (ctl.start) begin
      qlo_r <= qlo;
      qhi_r <= qhi;
    end
    if (push) begin
      lo_stk[d] <= lo;
      hi_stk[d] <= hi;
    end
  end

  assign sts.hit = run && !back && full;
  assign sts.fin = !run;
  assign node    = v;

endmodule

[hdl/grst_ctrl.sv]
// Sequencer and node store. Queries nest a column walk inside a row walk;
// updates record both paths, then rebuild every node on them bottom-up.
module grst_ctrl import grst_pkg::*; #(
  parameter int MAX_GRID  = 64,
  parameter int SUM_WIDTH = 32,
  localparam int RW   = $clog2(MAX_GRID > 1 ? MAX_GRID : 2),
  localparam int NW   = $clog2(MAX_GRID + 1),
  localparam int VW   = $clog2(4 * MAX_GRID),
  localparam int AW   = 2 * VW,
  localparam int SDEP = RW + 1,
  localparam int DW   = $clog2(SDEP),
  localparam int CW   = (NW > IDX_W) ? NW : IDX_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  grst_in_t      cmd,
  input  logic [NW-1:0] n,
  input  logic [RW-1:0] top,
  output logic          busy,
  output logic          done,
  output grst_out_t     result
);

  grst_state_t state, state_next;

  // node store
  logic [SUM_WIDTH-1:0] mem [2**AW];
  logic [SUM_WIDTH-1:0] rdata, wdata;
  logic [AW-1:0]        raddr, waddr, clr_addr;
  logic                 we;

  // item registers
  logic [RW-1:0]        row_q, col_q, c1_q, c2_q;
  logic [SUM_WIDTH-1:0] val, acc, a_reg;
  logic                 err_r, rd_pend;
  logic [VW-1:0]        vx;

  // path descent
  logic [RW-1:0] r_lo, r_hi, c_lo, c_hi, r_mid, c_mid;
  logic [VW-1:0] r_v, c_v;
  logic [DW-1:0] r_d, c_d, rl, cl, rleaf, cleaf;
  logic [VW-1:0] rpath [SDEP];
  logic [VW-1:0] cpath [SDEP];
  logic          r_at_leaf, c_at_leaf, both_leaf, col_leaf;
  logic [VW-1:0] vxp, vyp;

  // walkers
  walk_ctl_t     octl, ictl;
  walk_sts_t     osts, ists;
  logic [VW-1:0] onode, inode;

  // item decode
  logic [IDX_W-1:0] rmin, rmax, cmin, cmax;
  logic             err_in;

  always_comb begin
    rmin = (cmd.first_row <= cmd.second_row) ? cmd.first_row : cmd.second_row;
    rmax = (cmd.first_row <= cmd.second_row) ? cmd.second_row : cmd.first_row;
    cmin = (cmd.first_col <= cmd.second_col) ? cmd.first_col : cmd.second_col;
    cmax = (cmd.first_col <= cmd.second_col) ? cmd.second_col : cmd.first_col;
    if (cmd.kind == KIND_QUERY) begin
      err_in = (CW'(rmax) >= CW'(n)) || (CW'(cmax) >= CW'(n));
    end else begin
      err_in = (CW'(cmd.cell_row) >= CW'(n)) || (CW'(cmd.cell_col) >= CW'(n));
    end
  end

  grst_walk #(.MAX_GRID(MAX_GRID)) u_row_walk (
    .clk(clk), .rst(rst), .ctl(octl), .top(top),
    .qlo(RW'(rmin)), .qhi(RW'(rmax)), .sts(osts), .node(onode)
  );

  grst_walk #(.MAX_GRID(MAX_GRID)) u_col_walk (
    .clk(clk), .rst(rst), .ctl(ictl), .top(top),
    .qlo(c1_q), .qhi(c2_q), .sts(ists), .node(inode)
  );

  // update path helpers
  always_comb begin
    r_at_leaf = (r_lo == r_hi);
    c_at_leaf = (c_lo == c_hi);
    r_mid     = RW'(({1'b0, r_lo} + {1'b0, r_hi}) >> 1);
    c_mid     = RW'(({1'b0, c_lo} + {1'b0, c_hi}) >> 1);
    vxp       = rpath[rl];
    vyp       = cpath[cl];
    col_leaf  = (cl == cleaf);
    both_leaf = col_leaf && (rl == rleaf);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: if (clr_addr == '1) state_next = ST_IDLE;
      ST_IDLE: begin
        if (start) begin
          if (err_in) state_next = ST_DONE;
          else if (cmd.kind == KIND_QUERY) state_next = ST_QROW;
          else state_next = ST_UDESC;
        end
      end
      ST_QROW: begin
        if (osts.fin) state_next = ST_DONE;
        else if (osts.hit) state_next = ST_QCOL;
      end
      ST_QCOL: if (ists.fin) state_next = ST_QROW;
      ST_UDESC: if (r_at_leaf && c_at_leaf) state_next = ST_URDA;
      ST_URDA: state_next = both_leaf ? ST_UWR : ST_URDB;
      ST_URDB: state_next = ST_UWR;
      ST_UWR: begin
        if (cl != '0 || rl != '0) state_next = ST_URDA;
        else state_next = ST_DONE;
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs and store access
  always_comb begin
    busy       = (state != ST_IDLE);
    done       = (state == ST_DONE);
    octl.start = (state == ST_IDLE) && start && !err_in && (cmd.kind == KIND_QUERY);
    octl.adv   = (state == ST_QCOL) && ists.fin;
    ictl.start = (state == ST_QROW) && osts.hit && !osts.fin;
    ictl.adv   = (state == ST_QCOL);
    raddr      = {vx, inode};
    we         = 1'b0;
    waddr      = {vxp, vyp};
    wdata      = both_leaf ? val : SUM_WIDTH'(a_reg + rdata);
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = clr_addr;
        wdata = '0;
      end
      ST_URDA: raddr = col_leaf ? {VW'(vxp << 1), vyp} : {vxp, VW'(vyp << 1)};
      ST_URDB: raddr = col_leaf ? {VW'(vxp << 1) | VW'(1), vyp}
                                : {vxp, VW'(vyp << 1) | VW'(1)};
      ST_UWR:  we = 1'b1;
      default: ;
    endcase
    result.range_sum   = DATA_W'(acc);
    result.index_error = err_r;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      rd_pend  <= 1'b0;
    end else begin
      state    <= state_next;
      clr_addr <= (state == ST_CLEAR) ? AW'(clr_addr + 1'b1) : clr_addr;
      rd_pend  <= (state == ST_QCOL) && ists.hit;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      row_q <= RW'(cmd.cell_row);
      col_q <= RW'(cmd.cell_col);
      c1_q  <= RW'(cmin);
      c2_q  <= RW'(cmax);
      val   <= SUM_WIDTH'(cmd.new_value);
      err_r <= err_in;
      acc   <= '0;
      r_lo  <= '0;
      r_hi  <= top;
      r_v   <= VW'(1);
      r_d   <= '0;
      c_lo  <= '0;
      c_hi  <= top;
      c_v   <= VW'(1);
      c_d   <= '0;
    end else if (rd_pend) begin
      acc <= SUM_WIDTH'(acc + rdata);
    end

    if (ictl.start) vx <= onode;

    // record both update paths, one level a cycle
    if (state == ST_UDESC) begin
      rpath[r_d] <= r_v;
      cpath[c_d] <= c_v;
      if (!r_at_leaf) begin
        r_d <= DW'(r_d + 1'b1);
        if (row_q <= r_mid) begin
          r_v  <= VW'(r_v << 1);
          r_hi <= r_mid;
        end else begin
          r_v  <= VW'(r_v << 1) | VW'(1);
          r_lo <= RW'(r_mid + 1'b1);
        end
      end
      if (!c_at_leaf) begin
        c_d <= DW'(c_d + 1'b1);
        if (col_q <= c_mid) begin
          c_v  <= VW'(c_v << 1);
          c_hi <= c_mid;
        end else begin
          c_v  <= VW'(c_v << 1) | VW'(1);
          c_lo <= RW'(c_mid + 1'b1);
        end
      end
      rleaf <= r_d;
      cleaf <= c_d;
      rl    <= r_d;
      cl    <= c_d;
    end

    if (state == ST_URDB) a_reg <= rdata;

    // step to the next node: up the column path, then up one row level
    if (state == ST_UWR) begin
      if (cl != '0) begin
        cl <= DW'(cl - 1'b1);
      end else if (rl != '0) begin
        rl <= DW'(rl - 1'b1);
        cl <= cleaf;
      end
    end
  end

endmodule

[hdl/grst_check.sv]
module grst_check import grst_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input grst_in_t         cmd,
  input logic             done,
  input grst_out_t        result,
  input logic             cfg_valid,
  input logic             cfg_ready,
  input logic [CFG_W-1:0] cfg_data
);

  // a result only appears while an item is in hand
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

  // an accepted item holds the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("not busy after accept");

  // one strobe per item
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe longer than one cycle");

  // a flagged item carries no sum
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && result.index_error |-> result.range_sum == '0)
    else $error("index error with nonzero sum");

endmodule

bind grid_range_sum_tree grst_check u_check (.*);

[sim/testbench.sv]
module testbench;
  import grst_pkg::*;

  localparam int MAX_SIDE  = 64;
  localparam int TREE_SIDE = 4 * MAX_SIDE;
  localparam int RAND_ITEMS = 1600;
  localparam int IN_W = $bits(grst_in_t);

  logic             clk;
  logic             rst;
  logic             start;
  logic             busy;
  grst_in_t         cmd;
  logic             done;
  grst_out_t        result;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [CFG_W-1:0] cfg_data;

  grid_range_sum_tree u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // predictor state: mirror of the node store and the grid size register
  logic [31:0]      tree_sums [TREE_SIDE*TREE_SIDE];
  logic [CFG_W-1:0] grid_reg;
  int               grid_n;

  grst_out_t pending_sums[$];
  int        mismatch_count;
  int        result_count;
  int        update_count;
  int        query_count;
  int        error_count;

  // directed stimulus rows; has_gold marks rows with a typed-in answer
  typedef struct {
    grst_in_t  item;
    bit        has_gold;
    grst_out_t gold;
  } stim_row_t;

  function automatic int clamp_side(logic [CFG_W-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_SIDE) return MAX_SIDE;
    return int'(v);
  endfunction

  function automatic int node_at(int vx, int vy);
    return (vx % TREE_SIDE) * TREE_SIDE + (vy % TREE_SIDE);
  endfunction

  function automatic logic [31:0] sum_cols(int vx, int vy, int lo, int hi,
                                           int qlo, int qhi);
    int mid;
    if (qlo > qhi) return 0;
    if (qlo == lo && qhi == hi) return tree_sums[node_at(vx, vy)];
    mid = (lo + hi) / 2;
    return sum_cols(vx, 2*vy, lo, mid, qlo, (qhi < mid) ? qhi : mid)
         + sum_cols(vx, 2*vy+1, mid+1, hi, (qlo > mid+1) ? qlo : mid+1, qhi);
  endfunction

  function automatic logic [31:0] sum_rows(int vx, int lo, int hi, int qlo,
                                           int qhi, int c1, int c2);
    int mid;
    if (qlo > qhi) return 0;
    if (qlo == lo && qhi == hi) return sum_cols(vx, 1, 0, grid_n-1, c1, c2);
    mid = (lo + hi) / 2;
    return sum_rows(2*vx, lo, mid, qlo, (qhi < mid) ? qhi : mid, c1, c2)
         + sum_rows(2*vx+1, mid+1, hi, (qlo > mid+1) ? qlo : mid+1, qhi, c1, c2);
  endfunction

  function automatic void rebuild_cols(int vx, bit row_leaf, int vy, int lo,
                                       int hi, int col, logic [31:0] val);
    int mid;
    if (lo == hi) begin
      if (row_leaf) tree_sums[node_at(vx, vy)] = val;
      else tree_sums[node_at(vx, vy)] = tree_sums[node_at(2*vx, vy)]
                                      + tree_sums[node_at(2*vx+1, vy)];
      return;
    end
    mid = (lo + hi) / 2;
    if (col <= mid) rebuild_cols(vx, row_leaf, 2*vy, lo, mid, col, val);
    else rebuild_cols(vx, row_leaf, 2*vy+1, mid+1, hi, col, val);
    tree_sums[node_at(vx, vy)] = tree_sums[node_at(vx, 2*vy)]
                               + tree_sums[node_at(vx, 2*vy+1)];
  endfunction

  function automatic void rebuild_rows(int vx, int lo, int hi, int row, int col,
                                       logic [31:0] val);
    int mid;
    if (lo != hi) begin
      mid = (lo + hi) / 2;
      if (row <= mid) rebuild_rows(2*vx, lo, mid, row, col, val);
      else rebuild_rows(2*vx+1, mid+1, hi, row, col, val);
    end
    rebuild_cols(vx, lo == hi, 1, 0, grid_n-1, col, val);
  endfunction

  // apply one item to the mirror and return the expected result
  function automatic grst_out_t predict_sum(grst_in_t it);
    grst_out_t r;
    int r1, r2, c1, c2, t;
    r = '0;
    if (it.kind == KIND_UPDATE) begin
      update_count++;
      if (it.cell_row >= grid_n || it.cell_col >= grid_n) r.index_error = 1'b1;
      else rebuild_rows(1, 0, grid_n-1, it.cell_row, it.cell_col, it.new_value);
    end else begin
      query_count++;
      r1 = it.first_row; r2 = it.second_row;
      c1 = it.first_col; c2 = it.second_col;
      if (r1 > r2) begin t = r1; r1 = r2; r2 = t; end
      if (c1 > c2) begin t = c1; c1 = c2; c2 = t; end
      if (r2 >= grid_n || c2 >= grid_n) r.index_error = 1'b1;
      else r.range_sum = sum_rows(1, 0, grid_n-1, r1, r2, c1, c2);
    end
    if (r.index_error) error_count++;
    return r;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #400000000;
    $display("timeout");
    $display("grid_range_sum_tree verification failed");
    $finish;
  end

  // result checker
  always @(posedge clk) begin
    grst_out_t want;
    if (!rst && done) begin
      result_count++;
      if (pending_sums.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected result %0h", result);
      end else begin
        want = pending_sums.pop_front();
        if (result.range_sum !== want.range_sum ||
            result.index_error !== want.index_error) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: expected sum %0d err %0b, got sum %0d err %0b",
                     want.range_sum, want.index_error,
                     result.range_sum, result.index_error);
        end
      end
    end
  end

  task automatic idle_cycles(int n);
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    idle_cycles(4);
  endtask

  // issue one item; gap drawn per item, sometimes none. With no gap, start
  // stays high from the item before: the block is busy by then, so the
  // new item is the next one taken.
  task automatic send_item(grst_in_t it, bit has_gold, grst_out_t gold,
                           bit allow_gap);
    grst_out_t want;
    int gap;
    gap = allow_gap ? int'($urandom_range(0, 6)) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      idle_cycles(gap);
    end
    start <= 1'b1;
    cmd   <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = predict_sum(it);
    if (has_gold && want != gold) begin
      mismatch_count++;
      if (mismatch_count <= 10) $display("directed row disagrees with predictor");
    end
    pending_sums.push_back(want);
  endtask

  task automatic write_grid(logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    grid_reg = v;
    grid_n = clamp_side(v);
  endtask

  function automatic grst_in_t mk_update(int r, int c, logic [31:0] v);
    grst_in_t it;
    it = grst_in_t'(IN_W'({$urandom(), $urandom(), $urandom()}));
    it.kind = KIND_UPDATE;
    it.cell_row = IDX_W'(r);
    it.cell_col = IDX_W'(c);
    it.new_value = v;
    return it;
  endfunction

  function automatic grst_in_t mk_query(int r1, int r2, int c1, int c2);
    grst_in_t it;
    it = grst_in_t'(IN_W'({$urandom(), $urandom(), $urandom()}));
    it.kind = KIND_QUERY;
    it.first_row  = IDX_W'(r1);
    it.second_row = IDX_W'(r2);
    it.first_col  = IDX_W'(c1);
    it.second_col = IDX_W'(c2);
    return it;
  endfunction

  // random item sized to the current grid, with a few out-of-range indexes
  function automatic grst_in_t rand_item();
    grst_in_t it;
    int hi;
    hi = ($urandom_range(0, 15) == 0) ? 63 : grid_n - 1;
    it = grst_in_t'(IN_W'({$urandom(), $urandom(), $urandom()}));
    it.kind = ($urandom_range(0, 1) == 0) ? KIND_UPDATE : KIND_QUERY;
    it.cell_row   = IDX_W'($urandom_range(0, hi));
    it.cell_col   = IDX_W'($urandom_range(0, hi));
    it.first_row  = IDX_W'($urandom_range(0, hi));
    it.second_row = IDX_W'($urandom_range(0, hi));
    it.first_col  = IDX_W'($urandom_range(0, hi));
    it.second_col = IDX_W'($urandom_range(0, hi));
    return it;
  endfunction

  initial begin
    stim_row_t rows[$];
    grst_out_t gold;
    grst_out_t none;
    logic [CFG_W-1:0] phase_grid [6];
    int per_phase;
    rst = 1'b1; start = 1'b0; cmd = '0; cfg_valid = 1'b0; cfg_data = '0;
    mismatch_count = 0; result_count = 0;
    update_count = 0; query_count = 0; error_count = 0;
    foreach (tree_sums[i]) tree_sums[i] = '0;
    grid_reg = GRID_RESET;
    grid_n = clamp_side(GRID_RESET);
    none = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty tree, extremes, reversed bounds, wraparound
    gold = '0;
    rows.push_back('{mk_query(0, 63, 0, 63), 1, gold});
    rows.push_back('{mk_update(0, 0, 32'h7fffffff), 1, gold});
    rows.push_back('{mk_update(63, 63, 32'h80000000), 1, gold});
    gold.range_sum = 32'h7fffffff;
    rows.push_back('{mk_query(0, 0, 0, 0), 1, gold});
    gold.range_sum = 32'hffffffff;
    rows.push_back('{mk_query(63, 0, 63, 0), 1, gold});
    rows.push_back('{mk_update(0, 63, 32'h00000001), 0, none});
    rows.push_back('{mk_update(63, 0, 32'hffffffff), 0, none});
    rows.push_back('{mk_query(0, 63, 63, 0), 0, none});
    rows.push_back('{mk_query(31, 32, 0, 63), 0, none});
    rows.push_back('{mk_update(0, 0, 32'h7fffffff), 0, none});
    rows.push_back('{mk_query(0, 63, 0, 63), 0, none});
    rows.push_back('{mk_update(21, 42, 32'h55555555), 0, none});
    rows.push_back('{mk_query(42, 21, 21, 42), 0, none});
    rows.push_back('{mk_query(10, 10, 5, 50), 0, none});
    foreach (rows[i]) send_item(rows[i].item, rows[i].has_gold, rows[i].gold, 1);
    wait_drained();

    // small grid: indexes at the size must be flagged
    write_grid(7'd2);
    gold = '0; gold.index_error = 1'b1;
    send_item(mk_update(2, 0, 32'h1234), 1, gold, 0);
    send_item(mk_query(0, 0, 0, 2), 1, gold, 0);
    send_item(mk_update(1, 1, 32'h10), 0, none, 0);
    send_item(mk_query(1, 0, 1, 0), 0, none, 1);
    wait_drained();

    // grid size zero acts as one
    write_grid(7'd0);
    send_item(mk_update(0, 0, 32'hdeadbeef), 0, none, 0);
    send_item(mk_query(0, 0, 0, 0), 0, none, 0);
    send_item(mk_update(1, 0, 32'h5), 1, gold, 0);
    wait_drained();

    // random phases across several grid sizes, above-range value included
    phase_grid = '{7'd127, 7'd1, 7'd5, 7'd16, 7'd33, 7'd64};
    per_phase = RAND_ITEMS / 6;
    foreach (phase_grid[p]) begin
      write_grid(phase_grid[p]);
      for (int i = 0; i < per_phase; i++) begin
        bit burst;
        burst = (i % 100) < 30;
        send_item(rand_item(), 0, none, !burst);
        // sender holds off until everything is back
        if (i == per_phase / 2) begin
          start <= 1'b0;
          while (pending_sums.size() != 0) @(posedge clk);
        end
      end
      wait_drained();
    end

    idle_cycles(20);
    $display("ran %0d updates and %0d queries, %0d flagged out of range",
             update_count, query_count, error_count);
    $display("grid sizes 0 to 127 written, %0d results checked, %0d mismatches",
             result_count, mismatch_count);
    if (mismatch_count == 0 && pending_sums.size() == 0) begin
      $display("grid_range_sum_tree verification clean");
    end else begin
      $display("grid_range_sum_tree verification failed");
    end
    $finish;
  end

endmodule
